// File: sv/assert_macros.svh
// assertion macros shared by the hash block
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MMH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MMH_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/mmh_pkg.sv
// package for the murmur3 x64 128-bit hash block
// constants, command and status types, state codes and helper functions
`default_nettype none
package mmh_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int WORD_W = 64;
    localparam int IN_TDATA_W = 136;
    localparam int OUT_TDATA_W = 128;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = 1;

    localparam logic [63:0] MIX_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] FIN_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [4:0] BLOCK_BYTES = 5'd16;
    localparam logic [4:0] WORD_BYTES = 5'd8;

    typedef struct packed {
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic        absorb;
        logic        tail_one;
        logic        tail_two;
        logic        finish;
        logic [4:0]  add_len;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_CROSS_A,
        PH_CROSS_B,
        PH_SUM
    } mul_phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_K1A,
        S_K1B,
        S_H1ADD,
        S_H1FIN,
        S_K2A,
        S_K2B,
        S_H2ADD,
        S_H2FIN,
        S_FXOR,
        S_FADD1,
        S_FADD2,
        S_FSHIFT,
        S_F1M1,
        S_F1M2,
        S_F2M1,
        S_F2M2,
        S_FSUM1,
        S_FDONE
    } state_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

endpackage
`default_nettype wire

// File: sv/mmh_front.sv
// front end: takes input transactions, saturates the byte count and masks the tail
// depends on mmh_pkg
`default_nettype none
module mmh_front (
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [mmh_pkg::IN_TDATA_W-1:0]   s_tdata,  // block_low, block_high, valid_bytes
    input  wire logic                             s_tlast,  // last_block
    input  wire logic                             queue_full,
    output logic                                  push,
    output mmh_pkg::cmd_t                         cmd
);

    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  valid_bytes;
    logic [4:0]  cnt;
    logic [4:0]  high_cnt;
    logic [3:0]  n_low;
    logic [3:0]  n_high;
    logic        full_block;

    assign block_low = s_tdata[63:0];
    assign block_high = s_tdata[127:64];
    assign valid_bytes = s_tdata[132:128];

    assign s_tready = !queue_full;
    assign push = s_tvalid && !queue_full;

    always_comb
    begin
        cnt = (valid_bytes > mmh_pkg::BLOCK_BYTES) ? mmh_pkg::BLOCK_BYTES : valid_bytes;
        full_block = !s_tlast || (cnt == mmh_pkg::BLOCK_BYTES);
        high_cnt = cnt - mmh_pkg::WORD_BYTES;
        n_low = (cnt >= mmh_pkg::WORD_BYTES) ? 4'd8 : cnt[3:0];
        n_high = (cnt > mmh_pkg::WORD_BYTES) ? high_cnt[3:0] : 4'd0;

        cmd.absorb = full_block;
        cmd.tail_one = !full_block && (cnt != 5'd0);
        cmd.tail_two = !full_block && (cnt > mmh_pkg::WORD_BYTES);
        cmd.finish = s_tlast;
        cmd.add_len = s_tlast ? cnt : mmh_pkg::BLOCK_BYTES;
        cmd.word_low = full_block ? block_low : (block_low & mmh_pkg::byte_mask(n_low));
        cmd.word_high = full_block ? block_high : (block_high & mmh_pkg::byte_mask(n_high));
    end

endmodule
`default_nettype wire

// File: sv/mmh_queue.sv
// short command queue between the front end and the hash core
// depends on mmh_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module mmh_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mmh_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output mmh_pkg::cmd_t      pop_cmd,
    output logic               full,
    output logic               empty
);

    localparam logic [mmh_pkg::QUEUE_AW:0] DEPTH_CNT =
        (mmh_pkg::QUEUE_AW + 1)'(mmh_pkg::QUEUE_DEPTH);

    mmh_pkg::cmd_t                  entry_reg [mmh_pkg::QUEUE_DEPTH];
    logic [mmh_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mmh_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mmh_pkg::QUEUE_AW:0]     count_reg, count_next;

    assign full = count_reg == DEPTH_CNT;
    assign empty = count_reg == '0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `MMH_ASSERT(a_count_range, count_reg <= DEPTH_CNT, "queue count beyond depth")
    `MMH_ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")

endmodule
`default_nettype wire

// File: sv/mmh_mul.sv
// 64 by 64 multiplier keeping the low 64 bits, built on one 32 by 32 multiplier
// depends on mmh_pkg
`default_nettype none
module mmh_mul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [63:0]   a,
    input  wire logic [63:0]   b,
    output mmh_pkg::mul_stat_t stat,
    output logic [63:0]        result
);

    logic                busy_reg;
    logic                done_reg;
    mmh_pkg::mul_phase_t phase_reg, phase_next;
    logic [63:0]         a_reg;
    logic [63:0]         b_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         acc_reg;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [63:0]         partial;

    assign op_a = (phase_reg == mmh_pkg::PH_CROSS_B) ? a_reg[63:32] : a_reg[31:0];
    assign op_b = (phase_reg == mmh_pkg::PH_CROSS_A) ? b_reg[63:32] : b_reg[31:0];
    assign partial = op_a * op_b;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result = acc_reg;

    always_comb
    begin
        case (phase_reg)
            mmh_pkg::PH_LOW:     phase_next = mmh_pkg::PH_CROSS_A;
            mmh_pkg::PH_CROSS_A: phase_next = mmh_pkg::PH_CROSS_B;
            mmh_pkg::PH_CROSS_B: phase_next = mmh_pkg::PH_SUM;
            default:             phase_next = mmh_pkg::PH_LOW;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            phase_reg <= mmh_pkg::PH_LOW;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                phase_reg <= mmh_pkg::PH_LOW;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_next;
                if (phase_reg == mmh_pkg::PH_SUM)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
        begin
            prod_reg <= partial;
            case (phase_reg)
                mmh_pkg::PH_CROSS_A: acc_reg <= prod_reg;
                mmh_pkg::PH_CROSS_B: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                mmh_pkg::PH_SUM:     acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default:             acc_reg <= acc_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/mmh_core.sv
// hash core: sequencer that mixes blocks and runs the finalization
// depends on mmh_pkg, mmh_mul results and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module mmh_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              queue_empty,
    input  wire mmh_pkg::cmd_t                     queue_cmd,
    output logic                                   queue_pop,
    output logic                                   mul_start,
    output logic [63:0]                            mul_a,
    output logic [63:0]                            mul_b,
    input  wire mmh_pkg::mul_stat_t                mul_stat,
    input  wire logic [63:0]                       mul_result,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mmh_pkg::OUT_TDATA_W-1:0]        m_tdata  // hash_low, hash_high
);

    mmh_pkg::state_t                   state_reg, state_next;
    logic                              wait_reg, wait_next;
    logic [63:0]                       k1_reg;
    logic [63:0]                       k2_reg;
    logic [63:0]                       h1_reg;
    logic [63:0]                       h2_reg;
    logic [mmh_pkg::LENGTH_BITS-1:0]   len_reg;
    logic                              absorb_reg;
    logic                              tail_two_reg;
    logic                              finish_reg;
    logic                              out_valid_reg;
    logic [mmh_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                              mul_state;
    logic                              out_load;
    logic [63:0]                       fmix;
    logic [63:0]                       len_word;
    logic                              done;

    assign done = mul_stat.done;
    assign fmix = mul_result ^ (mul_result >> 33);
    assign len_word = 64'(len_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmh_pkg::S_IDLE:
            begin
                if (!queue_empty)
                begin
                    if (queue_cmd.absorb || queue_cmd.tail_one)
                    begin
                        state_next = mmh_pkg::S_K1A;
                    end
                    else
                    begin
                        state_next = mmh_pkg::S_FXOR;
                    end
                end
            end
            mmh_pkg::S_K1A: if (done) state_next = mmh_pkg::S_K1B;
            mmh_pkg::S_K1B:
            begin
                if (done)
                begin
                    if (absorb_reg)
                    begin
                        state_next = mmh_pkg::S_H1ADD;
                    end
                    else if (tail_two_reg)
                    begin
                        state_next = mmh_pkg::S_K2A;
                    end
                    else
                    begin
                        state_next = mmh_pkg::S_FXOR;
                    end
                end
            end
            mmh_pkg::S_H1ADD: state_next = mmh_pkg::S_H1FIN;
            mmh_pkg::S_H1FIN: state_next = mmh_pkg::S_K2A;
            mmh_pkg::S_K2A: if (done) state_next = mmh_pkg::S_K2B;
            mmh_pkg::S_K2B:
            begin
                if (done)
                begin
                    state_next = absorb_reg ? mmh_pkg::S_H2ADD : mmh_pkg::S_FXOR;
                end
            end
            mmh_pkg::S_H2ADD: state_next = mmh_pkg::S_H2FIN;
            mmh_pkg::S_H2FIN: state_next = finish_reg ? mmh_pkg::S_FXOR : mmh_pkg::S_IDLE;
            mmh_pkg::S_FXOR: state_next = mmh_pkg::S_FADD1;
            mmh_pkg::S_FADD1: state_next = mmh_pkg::S_FADD2;
            mmh_pkg::S_FADD2: state_next = mmh_pkg::S_FSHIFT;
            mmh_pkg::S_FSHIFT: state_next = mmh_pkg::S_F1M1;
            mmh_pkg::S_F1M1: if (done) state_next = mmh_pkg::S_F1M2;
            mmh_pkg::S_F1M2: if (done) state_next = mmh_pkg::S_F2M1;
            mmh_pkg::S_F2M1: if (done) state_next = mmh_pkg::S_F2M2;
            mmh_pkg::S_F2M2: if (done) state_next = mmh_pkg::S_FSUM1;
            mmh_pkg::S_FSUM1: state_next = mmh_pkg::S_FDONE;
            mmh_pkg::S_FDONE: if (!out_valid_reg || m_tready) state_next = mmh_pkg::S_IDLE;
            default: state_next = mmh_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        mul_state = state_reg inside {mmh_pkg::S_K1A, mmh_pkg::S_K1B, mmh_pkg::S_K2A,
                                      mmh_pkg::S_K2B, mmh_pkg::S_F1M1, mmh_pkg::S_F1M2,
                                      mmh_pkg::S_F2M1, mmh_pkg::S_F2M2};
        queue_pop = (state_reg == mmh_pkg::S_IDLE) && !queue_empty;
        mul_start = mul_state && !wait_reg;
        out_load = (state_reg == mmh_pkg::S_FDONE) && (!out_valid_reg || m_tready);
        wait_next = mul_start ? 1'b1 : (done ? 1'b0 : wait_reg);
        case (state_reg)
            mmh_pkg::S_K1A:
            begin
                mul_a = k1_reg;
                mul_b = mmh_pkg::MIX_C1;
            end
            mmh_pkg::S_K1B:
            begin
                mul_a = k1_reg;
                mul_b = mmh_pkg::MIX_C2;
            end
            mmh_pkg::S_K2A:
            begin
                mul_a = k2_reg;
                mul_b = mmh_pkg::MIX_C2;
            end
            mmh_pkg::S_K2B:
            begin
                mul_a = k2_reg;
                mul_b = mmh_pkg::MIX_C1;
            end
            mmh_pkg::S_F1M1:
            begin
                mul_a = h1_reg;
                mul_b = mmh_pkg::FIN_C1;
            end
            mmh_pkg::S_F1M2:
            begin
                mul_a = h1_reg;
                mul_b = mmh_pkg::FIN_C2;
            end
            mmh_pkg::S_F2M1:
            begin
                mul_a = h2_reg;
                mul_b = mmh_pkg::FIN_C1;
            end
            mmh_pkg::S_F2M2:
            begin
                mul_a = h2_reg;
                mul_b = mmh_pkg::FIN_C2;
            end
            default:
            begin
                mul_a = k1_reg;
                mul_b = mmh_pkg::MIX_C1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmh_pkg::S_IDLE;
            wait_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // running hash words and length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg <= '0;
            h2_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            case (state_reg)
                mmh_pkg::S_IDLE:
                begin
                    if (queue_pop)
                    begin
                        len_reg <= len_reg + mmh_pkg::LENGTH_BITS'(queue_cmd.add_len);
                    end
                end
                mmh_pkg::S_K1B: if (done) h1_reg <= h1_reg ^ mul_result;
                mmh_pkg::S_H1ADD: h1_reg <= mmh_pkg::rotl64(h1_reg, 27) + h2_reg;
                mmh_pkg::S_H1FIN: h1_reg <= (h1_reg << 2) + h1_reg + mmh_pkg::ADD_ONE;
                mmh_pkg::S_K2B: if (done) h2_reg <= h2_reg ^ mul_result;
                mmh_pkg::S_H2ADD: h2_reg <= mmh_pkg::rotl64(h2_reg, 31) + h1_reg;
                mmh_pkg::S_H2FIN: h2_reg <= (h2_reg << 2) + h2_reg + mmh_pkg::ADD_TWO;
                mmh_pkg::S_FXOR:
                begin
                    h1_reg <= h1_reg ^ len_word;
                    h2_reg <= h2_reg ^ len_word;
                end
                mmh_pkg::S_FADD1: h1_reg <= h1_reg + h2_reg;
                mmh_pkg::S_FADD2: h2_reg <= h2_reg + h1_reg;
                mmh_pkg::S_FSHIFT:
                begin
                    h1_reg <= h1_reg ^ (h1_reg >> 33);
                    h2_reg <= h2_reg ^ (h2_reg >> 33);
                end
                mmh_pkg::S_F1M1: if (done) h1_reg <= fmix;
                mmh_pkg::S_F1M2: if (done) h1_reg <= fmix;
                mmh_pkg::S_F2M1: if (done) h2_reg <= fmix;
                mmh_pkg::S_F2M2: if (done) h2_reg <= fmix;
                mmh_pkg::S_FSUM1: h1_reg <= h1_reg + h2_reg;
                mmh_pkg::S_FDONE:
                begin
                    if (out_load)
                    begin
                        h1_reg <= '0;
                        h2_reg <= '0;
                        len_reg <= '0;
                    end
                end
                default:
                begin
                    h1_reg <= h1_reg;
                end
            endcase
        end
    end

    // block words, command flags and result
    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            k1_reg <= queue_cmd.word_low;
            k2_reg <= queue_cmd.word_high;
            absorb_reg <= queue_cmd.absorb;
            tail_two_reg <= queue_cmd.tail_two;
            finish_reg <= queue_cmd.finish;
        end
        if ((state_reg == mmh_pkg::S_K1A) && done)
        begin
            k1_reg <= mmh_pkg::rotl64(mul_result, 31);
        end
        if ((state_reg == mmh_pkg::S_K2A) && done)
        begin
            k2_reg <= mmh_pkg::rotl64(mul_result, 33);
        end
        if (out_load)
        begin
            out_data_reg <= {h2_reg + h1_reg, h1_reg};
        end
    end

    `MMH_ASSERT(a_mul_idle, mul_start |-> !mul_stat.busy, "multiplier started while busy")
    `MMH_ASSERT(a_done_waits, mul_stat.done |-> wait_reg, "multiplier result nobody waits for")
    `MMH_ASSERT(a_load_clears, out_load |=> (h1_reg == '0) && (len_reg == '0),
                "hash state not cleared after result")

endmodule
`default_nettype wire

// File: sv/murmur3_x64_128_hash.sv
// top level of the murmur3 x64 128-bit hash block
// depends on mmh_pkg, mmh_front, mmh_queue, mmh_mul and mmh_core
//
// MurmurHash3 x64 128-bit with seed zero over a message streamed as 16-byte
// blocks on s_*, one hash per message on m_*. Every transaction before the last
// is a full block; the last carries 0 to 16 valid bytes (larger counts act as 16).
// The core mixes each full block, then the last block's tail (one word with one to
// eight bytes, two with more) and the finalization; all 64-bit products go through
// one shared 32x32 multiplier, which sets the rate. A two-entry command queue lets
// the input side run ahead of the core, and the result register lets the next
// message start while a hash waits to be taken.
`default_nettype none
module murmur3_x64_128_hash (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [mmh_pkg::IN_TDATA_W-1:0]   s_tdata,  // block_low, block_high, valid_bytes
    input  wire logic                             s_tlast,  // last_block
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mmh_pkg::OUT_TDATA_W-1:0]       m_tdata   // hash_low, hash_high
);

    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    mmh_pkg::cmd_t      push_cmd;
    mmh_pkg::cmd_t      pop_cmd;
    logic               mul_start;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    mmh_pkg::mul_stat_t mul_stat;
    logic [63:0]        mul_result;

    mmh_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    mmh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    mmh_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .stat   (mul_stat),
        .result (mul_result)
    );

    mmh_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_cmd   (pop_cmd),
        .queue_pop   (pop),
        .mul_start   (mul_start),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .mul_stat    (mul_stat),
        .mul_result  (mul_result),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

// File: dv/tb_murmur3_x64_128_hash.sv
`timescale 1ns / 1ps
// testbench for murmur3_x64_128_hash: streams messages as 16-byte block transactions
// and checks every 128-bit hash against a built-in murmur3 x64 128 predictor
// depends on mmh_pkg (port widths) and the murmur3_x64_128_hash rtl
module tb_murmur3_x64_128_hash;

    localparam bit [63:0] K_MUL1 = 64'h87c37b91114253d5;
    localparam bit [63:0] K_MUL2 = 64'h4cf5ad432745937f;
    localparam bit [63:0] H1_ADD = 64'h0000000052dce729;
    localparam bit [63:0] H2_ADD = 64'h0000000038495ab5;
    localparam bit [63:0] FMIX_MUL1 = 64'hff51afd7ed558ccd;
    localparam bit [63:0] FMIX_MUL2 = 64'hc4ceb9fe1a85ec53;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_WAIT = 200;

    typedef struct {
        bit [63:0] word_lo;
        bit [63:0] word_hi;
        bit [4:0]  byte_cnt;
        bit        ends_msg;
    } block_item_t;

    typedef struct {
        bit [63:0] lo;
        bit [63:0] hi;
    } digest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mmh_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mmh_pkg::OUT_TDATA_W-1:0] m_tdata;

    block_item_t blocks_pending[$];
    digest_t digests_due[$];

    bit [63:0] h1_run = '0;
    bit [63:0] h2_run = '0;
    bit [63:0] len_run = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    event hold_go;

    int unsigned errors = 0;
    int unsigned blocks_taken = 0;
    int unsigned hashes_checked = 0;
    int unsigned empty_tails = 0;
    int unsigned short_tails = 0;
    int unsigned full_tails = 0;
    int unsigned over_tails = 0;

    murmur3_x64_128_hash u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [63:0] rot_left(bit [63:0] v, int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic bit [63:0] scramble_k1(bit [63:0] k);
        bit [63:0] t;
        t = k * K_MUL1;
        t = rot_left(t, 31);
        return t * K_MUL2;
    endfunction

    function automatic bit [63:0] scramble_k2(bit [63:0] k);
        bit [63:0] t;
        t = k * K_MUL2;
        t = rot_left(t, 33);
        return t * K_MUL1;
    endfunction

    function automatic bit [63:0] fmix64(bit [63:0] h);
        bit [63:0] t;
        t = h ^ (h >> 33);
        t = t * FMIX_MUL1;
        t = t ^ (t >> 33);
        t = t * FMIX_MUL2;
        return t ^ (t >> 33);
    endfunction

    function automatic bit [63:0] keep_bytes(int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void absorb_full_block(bit [63:0] w0, bit [63:0] w1);
        h1_run = h1_run ^ scramble_k1(w0);
        h1_run = rot_left(h1_run, 27);
        h1_run = h1_run + h2_run;
        h1_run = h1_run * 64'd5 + H1_ADD;
        h2_run = h2_run ^ scramble_k2(w1);
        h2_run = rot_left(h2_run, 31);
        h2_run = h2_run + h1_run;
        h2_run = h2_run * 64'd5 + H2_ADD;
    endfunction

    // tail handling, length fold and finalization; clears the running state
    function automatic digest_t finish_message(bit [63:0] w0, bit [63:0] w1, bit [4:0] cnt_in);
        int unsigned cnt;
        bit [63:0] total;
        bit [63:0] a;
        bit [63:0] b;
        digest_t d;
        cnt = (cnt_in > 5'd16) ? 16 : cnt_in;
        if (cnt == 16)
            absorb_full_block(w0, w1);
        else if (cnt > 0)
        begin
            if (cnt > 8)
                h2_run = h2_run ^ scramble_k2(w1 & keep_bytes(cnt - 8));
            h1_run = h1_run ^ scramble_k1(w0 & keep_bytes(cnt));
        end
        total = len_run + 64'(cnt);
        a = h1_run ^ total;
        b = h2_run ^ total;
        a = a + b;
        b = b + a;
        a = fmix64(a);
        b = fmix64(b);
        a = a + b;
        b = b + a;
        d.lo = a;
        d.hi = b;
        h1_run = '0;
        h2_run = '0;
        len_run = '0;
        return d;
    endfunction

    function automatic bit [63:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_block(bit [63:0] w0, bit [63:0] w1, bit [4:0] cnt, bit fin);
        block_item_t it;
        it.word_lo = w0;
        it.word_hi = w1;
        it.byte_cnt = cnt;
        it.ends_msg = fin;
        blocks_pending.push_back(it);
    endfunction

    function automatic bit [4:0] random_tail_count();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return 5'd0;
        if (sel < 12)
            return 5'($urandom_range(17, 31));
        if (sel < 30)
            return 5'd16;
        return 5'($urandom_range(1, 15));
    endfunction

    function automatic void queue_message(int unsigned n_full, bit [4:0] tail_cnt);
        for (int i = 0; i < n_full; i++)
            queue_block(pick_word(), pick_word(), 5'($urandom_range(0, 31)), 1'b0);
        queue_block(pick_word(), pick_word(), tail_cnt, 1'b1);
    endfunction

    function automatic void queue_random_messages(int unsigned n_items);
        int unsigned pushed;
        int unsigned sel;
        int unsigned n_full;
        pushed = 0;
        while (pushed < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                n_full = 0;
            else if (sel < 80)
                n_full = $urandom_range(1, 3);
            else if (sel < 95)
                n_full = $urandom_range(4, 8);
            else
                n_full = $urandom_range(9, 20);
            queue_message(n_full, random_tail_count());
            pushed += n_full + 1;
        end
    endfunction

    task automatic drain_all();
        while (blocks_pending.size() != 0 || s_tvalid === 1'b1)
            @(posedge clk);
        while (digests_due.size() != 0)
            @(posedge clk);
    endtask

    // block transaction driver
    always @(posedge clk)
    begin
        block_item_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (blocks_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = blocks_pending.pop_front();
                s_tdata <= {3'b000, nxt.byte_cnt, nxt.word_hi, nxt.word_lo};
                s_tlast <= nxt.ends_msg;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // monitor: predict on accepted blocks, check accepted hashes
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                blocks_taken++;
                if (!s_tlast)
                begin
                    absorb_full_block(s_tdata[63:0], s_tdata[127:64]);
                    len_run = len_run + 64'd16;
                end
                else
                begin
                    if (s_tdata[132:128] == 5'd0)
                        empty_tails++;
                    else if (s_tdata[132:128] < 5'd16)
                        short_tails++;
                    else if (s_tdata[132:128] == 5'd16)
                        full_tails++;
                    else
                        over_tails++;
                    digests_due.push_back(finish_message(s_tdata[63:0], s_tdata[127:64],
                                                         s_tdata[132:128]));
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (digests_due.size() == 0)
                begin
                    $display("%0t: hash with none expected, expected none actual %h_%h",
                             $time, m_tdata[127:64], m_tdata[63:0]);
                    errors++;
                end
                else
                begin
                    want = digests_due.pop_front();
                    hashes_checked++;
                    if (m_tdata[63:0] !== want.lo)
                    begin
                        $display("%0t: hash_low mismatch, expected %h actual %h",
                                 $time, want.lo, m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[127:64] !== want.hi)
                    begin
                        $display("%0t: hash_high mismatch, expected %h actual %h",
                                 $time, want.hi, m_tdata[127:64]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: tail lengths around the word boundary, masking, odd counts
        queue_block('1, '1, 5'd16, 1'b1);
        queue_block('0, '0, 5'd16, 1'b1);
        queue_block('1, '1, 5'd1, 1'b1);
        queue_block('1, '1, 5'd8, 1'b1);
        queue_block('1, '1, 5'd9, 1'b1);
        queue_block('1, '1, 5'd15, 1'b1);
        queue_block(pick_word(), pick_word(), 5'd0, 1'b1);
        queue_block('1, '1, 5'd17, 1'b1);
        queue_block('1, '1, 5'd31, 1'b1);
        queue_block('1, '1, 5'd0, 1'b0);
        queue_block('1, '1, 5'd0, 1'b1);
        queue_block(pick_word(), pick_word(), 5'd31, 1'b0);
        queue_block(pick_word(), pick_word(), 5'd16, 1'b0);
        queue_block(pick_word(), pick_word(), 5'd7, 1'b1);
        queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd12, 1'b1);
        drain_all();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_messages(350);
        drain_all();

        send_idle_pct = 71;
        recv_stall_pct = 0;
        queue_random_messages(350);
        drain_all();

        send_idle_pct = 0;
        recv_stall_pct = 71;
        queue_random_messages(350);
        drain_all();

        send_idle_pct = 11;
        recv_stall_pct = 11;
        queue_random_messages(350);
        drain_all();

        // back-pressure: receiver holds off while single-block messages keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_go;
        for (int i = 0; i < 30; i++)
            queue_message(0, random_tail_count());
        drain_all();

        repeat (TAIL_WAIT) @(posedge clk);
        $display("run covered %0d block transactions and %0d hashes under idle, stall and hold-off",
                 blocks_taken, hashes_checked);
        $display("last blocks: %0d empty, %0d partial, %0d full, %0d with counts above sixteen",
                 empty_tails, short_tails, full_tails, over_tails);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
